>>> hw/rtl/mbdf_pkg.sv
// ----------------------------------------------------------------------------
// Mip downsample package
// Shared types, sizes and register codes for the 2x2 box mip level builder.
// ----------------------------------------------------------------------------
package mbdf_pkg;

  // Largest source image the line store and position counters are sized for.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Widths of the size registers and of the position counters.
  localparam int SIZE_W     = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // One line store entry holds the four pair sums of one column pair.
  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int PAIR_W     = 9;
  localparam int LINE_W     = 4 * PAIR_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Arithmetic widths: four-pixel sum, blend numerator, Q8 weight.
  localparam int SUM_W      = 10;
  localparam int NUM_W      = 18;
  localparam int WT_W       = 9;
  localparam logic [WT_W-1:0] WT_ONE = WT_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH    = 3'd0,
    REG_SRC_HEIGHT   = 3'd1,
    REG_FADE_COLOR   = 3'd2,
    REG_FADE_MODE    = 3'd3,
    REG_BLEND_WEIGHT = 3'd4
  } cfg_reg_t;

  // Source pixel.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_in_t;

  // Output pixel of the next mip level.
  typedef struct packed {
    logic       last;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_out_t;

  // Clamp a size register to 2..maxv and force it even.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] c;
    c = v;
    if (c < SIZE_W'(2)) c = SIZE_W'(2);
    if (c > maxv) c = maxv;
    return {c[SIZE_W-1:1], 1'b0};
  endfunction

endpackage

>>> hw/rtl/mbdf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module mbdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/mipmap_box_downsample_fade.sv
// ----------------------------------------------------------------------------
// Mip level builder
// 2x2 box downsample of an RGBA8 stream with optional fade and alpha scale.
// ----------------------------------------------------------------------------
// Source pixels are taken one per cycle unless stalled, in raster order, and
// each odd-row odd-column pixel produces one output pixel that passes
// through the sum register, loaded on the edge that takes it, then the
// blend multiply register, then the output register. Even rows leave their
// column pair sums in a single line store of MAX_WIDTH/2 entries, which sees
// at most one access per pixel: a write on the second pixel of a pair in an
// even row, a read on the first pixel of a pair in an odd row. Input stalls
// only when all three stages are full and the output is stalled.
// Configuration must be written while no pixel is in flight.
module mipmap_box_downsample_fade (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mbdf_pkg::pix_in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mbdf_pkg::pix_out_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbdf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [mbdf_pkg::SIZE_W-1:0] MAX_W_S = mbdf_pkg::SIZE_W'(mbdf_pkg::MAX_WIDTH);
  localparam logic [mbdf_pkg::SIZE_W-1:0] MAX_H_S =
    mbdf_pkg::SIZE_W'(mbdf_pkg::MAX_HEIGHT);

  // Configuration registers.
  logic [mbdf_pkg::SIZE_W-1:0] src_width_r;
  logic [mbdf_pkg::SIZE_W-1:0] src_height_r;
  logic [31:0]                 fade_color_r;
  logic [1:0]                  fade_mode_r;
  logic [mbdf_pkg::WT_W-1:0]   blend_weight_r;

  // Position and pixel state.
  logic [mbdf_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [mbdf_pkg::ROW_W-1:0]  row_r, row_nxt;
  mbdf_pkg::pix_in_t           left_pixel_r;

  // Pipeline stages.
  logic                        s1_valid_r;
  logic [mbdf_pkg::SUM_W-1:0]  s1_sum_r [4];
  logic                        s1_last_r;
  logic                        s2_valid_r;
  logic [mbdf_pkg::NUM_W-1:0]  s2_num_r [4];
  logic                        s2_last_r;
  logic                        out_valid_r;
  mbdf_pkg::pix_out_t          out_data_r;

  logic                        in_acc;
  logic                        out_load;
  logic                        s2_free;
  logic                        s1_free;
  logic                        s1_load;
  logic [mbdf_pkg::SIZE_W-1:0] eff_w;
  logic [mbdf_pkg::SIZE_W-1:0] eff_h;
  logic [mbdf_pkg::SIZE_W-1:0] col_inc;
  logic [mbdf_pkg::SIZE_W-1:0] row_inc;
  logic                        last_pos;

  logic [mbdf_pkg::LINE_AW-1:0] line_addr;
  logic                         line_we;
  logic                         line_re;
  logic [mbdf_pkg::LINE_W-1:0]  line_wdata;
  logic [mbdf_pkg::LINE_W-1:0]  line_rdata;

  logic [7:0]                  cur_ch  [4];
  logic [7:0]                  left_ch [4];
  logic [mbdf_pkg::SUM_W-1:0]  sum_nxt [4];
  logic [mbdf_pkg::NUM_W-1:0]  num_nxt [4];
  logic [7:0]                  fade_ch [4];
  logic [mbdf_pkg::WT_W-1:0]   wt;
  logic [mbdf_pkg::WT_W-1:0]   wt_inv;
  logic [18:0]                 blend_a [4];
  logic [18:0]                 blend_b [4];
  logic [21:0]                 alpha_x9;
  logic [8:0]                  alpha_v;

  // Handshake: each stage moves when the one after it has room.
  assign out_load  = !out_valid_r || !out_stall;
  assign s2_free   = !s2_valid_r || out_load;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_stall  = !s1_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign s1_load   = in_acc && col_r[0] && row_r[0];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r    <= mbdf_pkg::SIZE_W'(2);
      src_height_r   <= mbdf_pkg::SIZE_W'(2);
      fade_color_r   <= '0;
      fade_mode_r    <= '0;
      blend_weight_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (mbdf_pkg::cfg_reg_t'(cfg_index))
        mbdf_pkg::REG_SRC_WIDTH:    src_width_r    <= cfg_data[mbdf_pkg::SIZE_W-1:0];
        mbdf_pkg::REG_SRC_HEIGHT:   src_height_r   <= cfg_data[mbdf_pkg::SIZE_W-1:0];
        mbdf_pkg::REG_FADE_COLOR:   fade_color_r   <= cfg_data[31:0];
        mbdf_pkg::REG_FADE_MODE:    fade_mode_r    <= cfg_data[1:0];
        mbdf_pkg::REG_BLEND_WEIGHT: blend_weight_r <= cfg_data[mbdf_pkg::WT_W-1:0];
        default: ;
      endcase
    end
  end

  // Position counters: column wraps at the effective width, row at the height.
  always_comb begin
    eff_w    = mbdf_pkg::eff_size(src_width_r, MAX_W_S);
    eff_h    = mbdf_pkg::eff_size(src_height_r, MAX_H_S);
    col_inc  = mbdf_pkg::SIZE_W'(col_r) + mbdf_pkg::SIZE_W'(1);
    row_inc  = mbdf_pkg::SIZE_W'(row_r) + mbdf_pkg::SIZE_W'(1);
    last_pos = (mbdf_pkg::SIZE_W'(row_r) == eff_h - mbdf_pkg::SIZE_W'(1)) &&
               (mbdf_pkg::SIZE_W'(col_r) == eff_w - mbdf_pkg::SIZE_W'(1));
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (in_acc) begin
      if (col_inc >= eff_w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= eff_h) ? '0 : row_inc[mbdf_pkg::ROW_W-1:0];
      end else begin
        col_nxt = col_inc[mbdf_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      left_pixel_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_acc && !col_r[0]) begin
        left_pixel_r <= in_data;
      end
    end
  end

  // Pair sums of the current column pair, and four-pixel sums with the line above.
  always_comb begin
    cur_ch[0]  = in_data.red;
    cur_ch[1]  = in_data.green;
    cur_ch[2]  = in_data.blue;
    cur_ch[3]  = in_data.alpha;
    left_ch[0] = left_pixel_r.red;
    left_ch[1] = left_pixel_r.green;
    left_ch[2] = left_pixel_r.blue;
    left_ch[3] = left_pixel_r.alpha;
    for (int c = 0; c < 4; c++) begin
      line_wdata[c*mbdf_pkg::PAIR_W +: mbdf_pkg::PAIR_W] =
        {1'b0, left_ch[c]} + {1'b0, cur_ch[c]};
      sum_nxt[c] = {1'b0, line_wdata[c*mbdf_pkg::PAIR_W +: mbdf_pkg::PAIR_W]} +
                   {1'b0, line_rdata[c*mbdf_pkg::PAIR_W +: mbdf_pkg::PAIR_W]};
    end
  end

  // Line store: write on even rows, prefetch on the first pixel of odd-row pairs.
  assign line_addr = mbdf_pkg::LINE_AW'(col_r >> 1);
  assign line_we   = in_acc && col_r[0] && !row_r[0];
  assign line_re   = in_acc && !col_r[0] && row_r[0];

  mbdf_ram #(
    .WIDTH (mbdf_pkg::LINE_W),
    .DEPTH (mbdf_pkg::LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_addr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_addr),
    .rdata (line_rdata)
  );

  // Blend numerators: S*(256-w) + 4*m*w when faded, else S*256.
  always_comb begin
    fade_ch[0] = fade_color_r[23:16];
    fade_ch[1] = fade_color_r[15:8];
    fade_ch[2] = fade_color_r[7:0];
    fade_ch[3] = fade_color_r[31:24];
    wt     = (blend_weight_r > mbdf_pkg::WT_ONE) ? mbdf_pkg::WT_ONE : blend_weight_r;
    wt_inv = mbdf_pkg::WT_ONE - wt;
    for (int c = 0; c < 4; c++) begin
      blend_a[c] = 19'(s1_sum_r[c]) * 19'(wt_inv);
      blend_b[c] = {19'(fade_ch[c]) * 19'(wt)} << 2;
      if ((c < 3) ? fade_mode_r[0] : fade_mode_r[1]) begin
        num_nxt[c] = mbdf_pkg::NUM_W'(blend_a[c] + blend_b[c]);
      end else begin
        num_nxt[c] = {s1_sum_r[c], 8'h00};
      end
    end
  end

  // Alpha is scaled by nine eighths and saturated; colors cannot exceed 255.
  always_comb begin
    alpha_x9 = {s2_num_r[3], 3'b000} + 22'(s2_num_r[3]);
    alpha_v  = alpha_x9[21:13];
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= s1_load;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_load) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (s1_free && s1_load) begin
      s1_sum_r  <= sum_nxt;
      s1_last_r <= last_pos;
    end
    if (s2_free && s1_valid_r) begin
      s2_num_r  <= num_nxt;
      s2_last_r <= s1_last_r;
    end
    if (out_load && s2_valid_r) begin
      out_data_r.red   <= s2_num_r[0][mbdf_pkg::NUM_W-1 -: 8];
      out_data_r.green <= s2_num_r[1][mbdf_pkg::NUM_W-1 -: 8];
      out_data_r.blue  <= s2_num_r[2][mbdf_pkg::NUM_W-1 -: 8];
      out_data_r.alpha <= alpha_v[8] ? 8'hFF : alpha_v[7:0];
      out_data_r.last  <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Input backpressure only comes from a full pipeline behind a stalled output.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  // The line store never sees a read and a write in the same cycle.
  a_line_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(line_we && line_re))
    else $error("line store read and write collide");

  // A result leaving the multiply stage lands in the output register.
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && out_load) |=> out_valid_r)
    else $error("result lost between multiply stage and output");
`endif

endmodule

>>> tb/mipmap_box_downsample_fade_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mip level builder checker
// Watches the pixel, result and register channels of the mip level builder.
// It keeps its own model of the 2x2 box average with fade and compares every
// output pixel, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_fade_check (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  mbdf_pkg::pix_in_t                   in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  mbdf_pkg::pix_out_t                  out_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [mbdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbdf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  mismatch_count,
  output int                                  results_pending
);
  import mbdf_pkg::*;

  // Register copies.
  logic [SIZE_W-1:0]     width_reg;
  logic [SIZE_W-1:0]     height_reg;
  logic [31:0]           fade_reg;
  logic [1:0]            mode_reg;
  logic [WT_W-1:0]       weight_reg;

  // Model state: line of pair sums, held even-column pixel, source position.
  logic [LINE_W-1:0]     pair_sums [LINE_DEPTH];
  logic [31:0]           left_px;
  int unsigned           col_pos;
  int unsigned           row_pos;

  pix_out_t              mip_expected [$];
  int                    errors = 0;
  int                    results_seen = 0;

  assign mismatch_count = errors;

  // Effective image size: clamped to 2..cap and rounded down to even.
  function automatic int unsigned even_dim(input logic [SIZE_W-1:0] raw,
                                           input int unsigned cap);
    int unsigned d;
    d = 32'(raw);
    if (d < 2) d = 2;
    if (d > cap) d = cap;
    return d & ~32'd1;
  endfunction

  task automatic report_mismatch(input string what, input logic [32:0] got,
                                 input logic [32:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %0h expected %0h",
             results_seen, what, got, want);
  endtask

  // Advance the model by one source pixel and queue the output it produces.
  task automatic predict_mip_pixel(input logic [31:0] px);
    int unsigned       w_eff;
    int unsigned       h_eff;
    int unsigned       wt;
    int unsigned       s;
    int unsigned       num;
    int unsigned       v;
    int unsigned       idx;
    logic [LINE_W-1:0] pair;
    logic [LINE_W-1:0] above;
    logic [31:0]       fade_rgba;
    logic [31:0]       avg;
    logic              faded;
    w_eff = even_dim(width_reg, MAX_WIDTH);
    h_eff = even_dim(height_reg, MAX_HEIGHT);
    if (col_pos % 2 == 0) begin
      left_px = px;
    end else begin
      idx = (col_pos / 2) % LINE_DEPTH;
      for (int c = 0; c < 4; c++) begin
        pair[PAIR_W*c +: PAIR_W] = PAIR_W'(left_px[8*c +: 8]) + PAIR_W'(px[8*c +: 8]);
      end
      if (row_pos % 2 == 0) begin
        pair_sums[idx] = pair;
      end else begin
        above = pair_sums[idx];
        wt = (weight_reg > WT_ONE) ? 256 : 32'(weight_reg);
        // Fade bytes rearranged into the pixel's red-lowest byte order.
        fade_rgba = {fade_reg[31:24], fade_reg[7:0], fade_reg[15:8], fade_reg[23:16]};
        for (int c = 0; c < 4; c++) begin
          s = 32'(pair[PAIR_W*c +: PAIR_W]) + 32'(above[PAIR_W*c +: PAIR_W]);
          faded = (c < 3) ? mode_reg[0] : mode_reg[1];
          if (faded) num = s * (256 - wt) + 4 * 32'(fade_rgba[8*c +: 8]) * wt;
          else num = s * 256;
          v = (c < 3) ? (num >> 10) : ((9 * num) >> 13);
          avg[8*c +: 8] = (v > 255) ? 8'hFF : v[7:0];
        end
        mip_expected.push_back(pix_out_t'({row_pos == h_eff - 1 && col_pos == w_eff - 1,
                                           avg}));
      end
    end
    col_pos++;
    if (col_pos >= w_eff) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h_eff) row_pos = 0;
    end
  endtask

  // Track register writes, check results and predict on accepted pixels.
  always @(posedge clk) begin : monitor
    pix_out_t want;
    if (!rst_n) begin
      width_reg  = SIZE_W'(2);
      height_reg = SIZE_W'(2);
      fade_reg   = '0;
      mode_reg   = '0;
      weight_reg = '0;
      left_px    = '0;
      col_pos    = 0;
      row_pos    = 0;
      mip_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_SRC_WIDTH:    width_reg  = cfg_data[SIZE_W-1:0];
          REG_SRC_HEIGHT:   height_reg = cfg_data[SIZE_W-1:0];
          REG_FADE_COLOR:   fade_reg   = cfg_data;
          REG_FADE_MODE:    mode_reg   = cfg_data[1:0];
          REG_BLEND_WEIGHT: weight_reg = cfg_data[WT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (mip_expected.size() == 0) begin
          report_mismatch("output pixel with none expected", out_data, '0);
        end else begin
          want = mip_expected.pop_front();
          if (out_data.red !== want.red) report_mismatch("red", out_data.red, want.red);
          if (out_data.green !== want.green)
            report_mismatch("green", out_data.green, want.green);
          if (out_data.blue !== want.blue) report_mismatch("blue", out_data.blue, want.blue);
          if (out_data.alpha !== want.alpha)
            report_mismatch("alpha", out_data.alpha, want.alpha);
          if (out_data.last !== want.last) report_mismatch("last", out_data.last, want.last);
        end
      end
      if (in_valid && !in_stall) predict_mip_pixel(in_data);
    end
    results_pending <= mip_expected.size();
  end

endmodule

>>> tb/mipmap_box_downsample_fade_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mip level builder testbench
// Feeds corner-case and random pixel streams under a series of size, fade
// and weight settings, with random gaps on both sides, and leaves checking
// to the checker instance.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_fade_test;
  import mbdf_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int CALM_AFTER   = 760;
  localparam int QUIET_LIMIT  = 1000;
  localparam int SIZE_MAX_RAW = (1 << SIZE_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pix_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pix_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                    mismatch_count;
  int                    results_pending;
  int                    in_gap_pct = 20;
  int                    out_gap_pct = 20;
  int                    stall_left = 0;
  int                    quiet_cycles = 0;
  logic [31:0]           corner_pixels [20];

  always #5 clk = ~clk;

  mipmap_box_downsample_fade dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mipmap_box_downsample_fade_check checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // Output back-pressure comes in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if ($urandom_range(0, 99) < out_gap_pct) begin
      stall_left = $urandom_range(0, 8);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Give up when no channel has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[mipmap_box_downsample_fade] ERROR");
      $finish;
    end
  end

  // Present one source pixel, after an optional idle burst, until taken.
  task automatic send_pixel(input logic [31:0] px);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = pix_in_t'(px);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (results_pending != 0) @(negedge clk);
  endtask

  // Pick one of the register values that map onto the given even size:
  // the size itself, the odd value above it, or for 2 or cap a value clamped to it.
  function automatic logic [SIZE_W-1:0] size_code(input int unsigned dim,
                                                  input int unsigned cap);
    int unsigned raw;
    raw = dim;
    case ($urandom_range(0, 2))
      1: raw = dim + 1;
      2: begin
        if (dim == 2) raw = $urandom_range(0, 1);
        else if (dim == cap) raw = $urandom_range(cap, SIZE_MAX_RAW);
      end
      default: ;
    endcase
    return SIZE_W'(raw);
  endfunction

  initial begin
    int unsigned       w_eff;
    int unsigned       h_eff;
    int unsigned       n_pix;
    int unsigned       random_sent;
    int unsigned       phase;
    logic [SIZE_W-1:0] w_raw;
    logic [SIZE_W-1:0] h_raw;
    logic [1:0]        mode;
    logic [WT_W-1:0]   weight;
    logic [31:0]       fade;
    logic [31:0]       px;

    // Corner pixels, four per 2x2 level under the reset settings: black,
    // white, half white, alternating bit patterns, and alpha sums on either
    // side of the point where the nine-eighths scale saturates.
    corner_pixels = '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
                      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                      32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000,
                      32'h55AA55AA, 32'h55AA55AA, 32'hAA55AA55, 32'hAA55AA55,
                      32'hE301807F, 32'hE3FE7F80, 32'hE2FF0001, 32'hE3000100};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);

    // Random phases. Each one starts idle at an even row, column zero, and
    // sends whole row pairs, so no line entry is read before it is written.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) w_eff = 2 * $urandom_range(1, 8);
      else w_eff = 2 * $urandom_range(9, 32);
      if (phase == 6) w_eff = 2;
      h_eff = ($urandom_range(0, 6) == 0) ? MAX_HEIGHT : 2 * $urandom_range(1, 6);
      w_raw = size_code(w_eff, MAX_WIDTH);
      h_raw = (phase == 6) ? SIZE_W'(SIZE_MAX_RAW) : size_code(h_eff, MAX_HEIGHT);

      // The first phases walk through every fade mode and the weight corners.
      if (phase < 4) begin
        mode = phase[1:0];
        case (phase)
          0: weight = WT_W'(256);
          1: weight = WT_W'(511);
          2: weight = '0;
          default: weight = WT_W'(128);
        endcase
      end else begin
        mode = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0, 1: weight = '0;
          2, 3: weight = WT_W'(256);
          4: weight = WT_W'($urandom_range(257, 511));
          default: weight = WT_W'($urandom_range(1, 255));
        endcase
      end
      case ($urandom_range(0, 7))
        0: fade = '0;
        1: fade = '1;
        default: fade = $urandom;
      endcase

      if (random_sent >= CALM_AFTER) begin
        in_gap_pct = 0;
        out_gap_pct = 0;
      end else begin
        in_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        out_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end

      // Registers change only with nothing in flight.
      in_valid = 1'b0;
      wait_drained();
      repeat (4) @(negedge clk);
      write_reg(REG_SRC_WIDTH, 32'(w_raw));
      write_reg(REG_SRC_HEIGHT, 32'(h_raw));
      write_reg(REG_FADE_COLOR, fade);
      write_reg(REG_FADE_MODE, 32'(mode));
      write_reg(REG_BLEND_WEIGHT, 32'(weight));

      n_pix = 2 * w_eff * $urandom_range(1, 96 / w_eff);

      for (int unsigned i = 0; i < n_pix; i++) begin
        px = $urandom;
        for (int c = 0; c < 4; c++) begin
          case ($urandom_range(0, 9))
            0: px[8*c +: 8] = 8'h00;
            1: px[8*c +: 8] = 8'hFF;
            default: ;
          endcase
        end
        // Now and then hold the stream until the pipeline has emptied.
        if ($urandom_range(0, 199) == 0) begin
          in_valid = 1'b0;
          wait_drained();
        end
        if (random_sent >= CALM_AFTER) begin
          in_gap_pct = 0;
          out_gap_pct = 0;
        end
        send_pixel(px);
        random_sent++;
      end
      phase++;
    end

    in_valid = 1'b0;
    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[mipmap_box_downsample_fade] OK");
    end else begin
      $display("[mipmap_box_downsample_fade] ERROR");
    end
    $finish;
  end

endmodule
